// ----- hw/rtl/biq_pkg.sv -----
// ----------------------------------------------------------------------------
// biq_pkg: shared types and constants for the Q15 biquad filter
// Coefficient set, register indexes, reset values, datapath widths, rounding bias and clip limits.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int COEF_W = 16;
  localparam int SAMP_W = 16;
  localparam int PROD_W = 2 * COEF_W;
  localparam int TERM_W = PROD_W - 15;
  localparam int SUM_W  = TERM_W + 3;
  localparam int IDX_W  = 3;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [SAMP_W-1:0] samp_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  localparam logic [IDX_W-1:0] REG_B0 = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_B1 = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_B2 = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_A1 = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_A2 = IDX_W'(4);

  localparam coef_t B0_RESET = COEF_W'(16'h10C8);
  localparam coef_t B1_RESET = COEF_W'(16'h2190);
  localparam coef_t B2_RESET = COEF_W'(16'h10C8);
  localparam coef_t A1_RESET = COEF_W'(16'h5FB7);
  localparam coef_t A2_RESET = COEF_W'(16'hDD28);

  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1 << 14);

  localparam sum_t  SAT_HIGH     = SUM_W'(32767);
  localparam sum_t  SAT_LOW      = SUM_W'(-32767);
  localparam samp_t OUT_MIN_CODE = SAMP_W'(16'h8000);

endpackage

// ----- hw/rtl/biq_coef_regs.sv -----
// ----------------------------------------------------------------------------
// biq_coef_regs: coefficient register file
// Five Q15 coefficients, written one at a time by index; unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
module biq_coef_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [biq_pkg::IDX_W-1:0] cfg_index,
  input  biq_pkg::coef_t           cfg_data,
  output biq_pkg::coef_set_t       coefs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0 <= biq_pkg::B0_RESET;
      coefs.b1 <= biq_pkg::B1_RESET;
      coefs.b2 <= biq_pkg::B2_RESET;
      coefs.a1 <= biq_pkg::A1_RESET;
      coefs.a2 <= biq_pkg::A2_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        biq_pkg::REG_B0: coefs.b0 <= cfg_data;
        biq_pkg::REG_B1: coefs.b1 <= cfg_data;
        biq_pkg::REG_B2: coefs.b2 <= cfg_data;
        biq_pkg::REG_A1: coefs.a1 <= cfg_data;
        biq_pkg::REG_A2: coefs.a2 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/biq_term.sv -----
// ----------------------------------------------------------------------------
// biq_term: one rounded Q15 product term
// p = c*s + 2^14; result is p >>> 15 with the sticky low bits folded into
// the result LSB.
// ----------------------------------------------------------------------------
module biq_term (
  input  biq_pkg::coef_t coef,
  input  biq_pkg::samp_t samp,
  output biq_pkg::term_t term
);

  logic signed [biq_pkg::PROD_W-1:0] prod;
  logic signed [biq_pkg::PROD_W-1:0] biased;

  assign prod   = biq_pkg::PROD_W'(coef) * biq_pkg::PROD_W'(samp);
  assign biased = prod + biq_pkg::ROUND_BIAS;
  // (p | 0x8000) >>> 15 when the low half is nonzero, else p >>> 15
  assign term   = {biased[biq_pkg::PROD_W-1:16], |biased[15:0]};

endmodule

// ----- hw/rtl/biquad_iir_q15_unit.sv -----
// ----------------------------------------------------------------------------
// biquad_iir_q15_unit: direct form 1 biquad, Q15 fixed point
// Input samples enter on x_valid/x_ready, filtered samples leave on
// y_valid/y_ready. Each transaction carries one signed 16-bit sample.
// Coefficients are written through cfg_wr_en/cfg_index/cfg_data:
// 0 b0, 1 b1, 2 b2, 3 a1, 4 a2 (feedback signs folded in); write only
// while the filter is idle.
// A sample accepted into the input register moves on to the output register,
// y_sample, when that register is empty or being read. Throughput is one
// sample per cycle while the receiver keeps y_ready high: the five multipliers,
// the adder and the clip sit between the input register and the output register.
// Reset (rst, synchronous) empties both registers, clears the four delay
// taps and loads the default low-pass coefficients.
// When the receiver holds y_ready low, the output register keeps its
// sample, the input register fills, and x_ready falls one sample later.
// The delay taps advance only when a sample moves into the output register.
// ----------------------------------------------------------------------------
module biquad_iir_q15_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      x_valid,
  output logic                      x_ready,
  input  biq_pkg::samp_t            x_sample,
  output logic                      y_valid,
  input  logic                      y_ready,
  output biq_pkg::samp_t            y_sample,
  input  logic                      cfg_wr_en,
  input  logic [biq_pkg::IDX_W-1:0] cfg_index,
  input  biq_pkg::coef_t            cfg_data
);

  biq_pkg::coef_set_t coefs;
  logic               s1_valid;
  biq_pkg::samp_t     s1_x;
  logic               advance;
  biq_pkg::samp_t     x_delay_one;
  biq_pkg::samp_t     x_delay_two;
  biq_pkg::samp_t     y_delay_one;
  biq_pkg::samp_t     y_delay_two;
  biq_pkg::term_t     t_b0;
  biq_pkg::term_t     t_b1;
  biq_pkg::term_t     t_b2;
  biq_pkg::term_t     t_a1;
  biq_pkg::term_t     t_a2;
  biq_pkg::sum_t      sum;
  biq_pkg::samp_t     y_next;

  biq_coef_regs u_coef_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  biq_term u_term_b0 (.coef(coefs.b0), .samp(s1_x),        .term(t_b0));
  biq_term u_term_b1 (.coef(coefs.b1), .samp(x_delay_one), .term(t_b1));
  biq_term u_term_b2 (.coef(coefs.b2), .samp(x_delay_two), .term(t_b2));
  biq_term u_term_a1 (.coef(coefs.a1), .samp(y_delay_one), .term(t_a1));
  biq_term u_term_a2 (.coef(coefs.a2), .samp(y_delay_two), .term(t_a2));

  assign advance = s1_valid && (!y_valid || y_ready);
  assign x_ready = !s1_valid || advance;

  always_comb begin
    sum = biq_pkg::SUM_W'(t_b0) + biq_pkg::SUM_W'(t_b1) + biq_pkg::SUM_W'(t_b2)
        + biq_pkg::SUM_W'(t_a1) + biq_pkg::SUM_W'(t_a2);
    if (sum >= biq_pkg::SAT_HIGH) begin
      y_next = biq_pkg::SAMP_W'(biq_pkg::SAT_HIGH);
    end else if (sum <= biq_pkg::SAT_LOW) begin
      y_next = biq_pkg::SAMP_W'(biq_pkg::SAT_LOW);
    end else begin
      y_next = sum[biq_pkg::SAMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (x_ready) begin
      s1_valid <= x_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (x_valid && x_ready) begin
      s1_x <= x_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y_valid <= 1'b0;
    end else if (advance) begin
      y_valid <= 1'b1;
    end else if (y_ready) begin
      y_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      y_sample <= y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_delay_one <= '0;
      x_delay_two <= '0;
      y_delay_one <= '0;
      y_delay_two <= '0;
    end else if (advance) begin
      x_delay_one <= s1_x;
      x_delay_two <= x_delay_one;
      y_delay_one <= y_next;
      y_delay_two <= y_delay_one;
    end
  end

`ifndef ASSERT_OFF
  a_no_min_code: assert property (@(posedge clk) disable iff (rst)
    y_valid |-> (y_sample != biq_pkg::OUT_MIN_CODE))
    else $error("output reached the negative full-scale code");

  a_tap_matches_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> (y_valid && (y_delay_one == y_sample)))
    else $error("feedback tap out of step with the output register");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    !x_ready |-> (s1_valid && y_valid && !y_ready))
    else $error("input stalled without a held transaction");

  a_x_tap_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> (x_delay_one == $past(s1_x)))
    else $error("input tap did not take the processed sample");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: Q15 direct form 1 biquad, self-checking
// Drives samples over the x channel with random gaps and random y_ready
// stalls, including one long receiver hold that backs up the pipeline.
// Every accepted sample is run through a bit-exact filter model; each
// output transaction is checked against the oldest predicted sample.
// Coefficients are rewritten between phases, with edge values and
// ignored out-of-range register writes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 215;
  localparam int DRAIN_CYCLES = 4;
  localparam int LONG_HOLD    = 90;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic x_valid = 1'b0;
  logic x_ready;
  biq_pkg::samp_t x_sample = '0;
  logic y_valid;
  logic y_ready = 1'b0;
  biq_pkg::samp_t y_sample;
  logic cfg_wr_en = 1'b0;
  logic [biq_pkg::IDX_W-1:0] cfg_index = biq_pkg::REG_B0;
  biq_pkg::coef_t cfg_data = '0;

  biquad_iir_q15_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .x_valid   (x_valid),
    .x_ready   (x_ready),
    .x_sample  (x_sample),
    .y_valid   (y_valid),
    .y_ready   (y_ready),
    .y_sample  (y_sample),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // filter model state
  biq_pkg::coef_set_t coefs = '{b0: biq_pkg::B0_RESET, b1: biq_pkg::B1_RESET,
                                b2: biq_pkg::B2_RESET, a1: biq_pkg::A1_RESET,
                                a2: biq_pkg::A2_RESET};
  biq_pkg::samp_t x_tap1 = '0, x_tap2 = '0, y_tap1 = '0, y_tap2 = '0;

  biq_pkg::samp_t x_pending_q[$];
  biq_pkg::samp_t y_expected_q[$];
  int    mismatches = 0;
  bit    x_idle_on = 1'b1;
  bit    y_idle_on = 1'b1;
  int    hold_req = 0;

  function automatic logic signed [63:0] q15_product(biq_pkg::coef_t c,
                                                     biq_pkg::samp_t s);
    logic signed [63:0] cw, sw, p;
    cw = 64'(c);
    sw = 64'(s);
    p = cw * sw + 64'sd16384;
    if (p[15:0] != 16'h0000)
      p = p | 64'sh8000;
    return p >>> 15;
  endfunction

  function automatic biq_pkg::samp_t filter_step(biq_pkg::samp_t x);
    logic signed [63:0] acc;
    biq_pkg::samp_t y;
    acc = q15_product(coefs.b0, x) + q15_product(coefs.b1, x_tap1)
        + q15_product(coefs.b2, x_tap2) + q15_product(coefs.a1, y_tap1)
        + q15_product(coefs.a2, y_tap2);
    if (acc >= 64'(biq_pkg::SAT_HIGH))
      y = biq_pkg::samp_t'(biq_pkg::SAT_HIGH);
    else if (acc <= 64'(biq_pkg::SAT_LOW))
      y = biq_pkg::samp_t'(biq_pkg::SAT_LOW);
    else
      y = acc[biq_pkg::SAMP_W-1:0];
    x_tap2 = x_tap1;
    x_tap1 = x;
    y_tap2 = y_tap1;
    y_tap1 = y;
    return y;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic biq_pkg::samp_t pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return biq_pkg::samp_t'(int'($urandom_range(0, 511)) - 256);
      3: return biq_pkg::samp_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return biq_pkg::samp_t'($urandom);
    endcase
  endfunction

  function automatic biq_pkg::coef_t pick_coef();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return biq_pkg::coef_t'($urandom);
    endcase
  endfunction

  // sender
  always @(posedge clk) begin : tx_side
    if (rst) begin
      x_valid <= 1'b0;
      x_sample <= '0;
    end else begin
      int unsigned x_wait;
      if (x_valid && x_ready)
        y_expected_q.push_back(filter_step(x_sample));
      if (!x_valid || x_ready) begin
        if (x_wait > 0) begin
          x_valid <= 1'b0;
          x_wait = x_wait - 1;
        end else if (x_pending_q.size() > 0) begin
          x_valid <= 1'b1;
          x_sample <= x_pending_q.pop_front();
          x_wait = x_idle_on ? idle_len() : 0;
        end else begin
          x_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : rx_side
    biq_pkg::samp_t want_y;
    int    hold_cnt;
    int    hold_seen;
    int    g;
    if (rst) begin
      y_ready <= 1'b0;
      hold_cnt = 0;
      hold_seen = 0;
    end else begin
      if (y_valid && y_ready) begin
        if (y_expected_q.size() == 0) begin
          $error("unexpected y_sample transaction: actual %0d", y_sample);
          mismatches++;
        end else begin
          want_y = y_expected_q.pop_front();
          if (y_sample !== want_y) begin
            $error("y_sample mismatch: expected %0d, actual %0d", want_y, y_sample);
            mismatches++;
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        y_ready <= 1'b0;
      end else if (!y_idle_on) begin
        y_ready <= 1'b1;
      end else begin
        g = idle_len();
        y_ready <= (g == 0);
        if (g > 0)
          hold_cnt = g - 1;
      end
    end
  end

  task automatic cfg_write(input logic [biq_pkg::IDX_W-1:0] idx,
                           input biq_pkg::coef_t val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      biq_pkg::REG_B0: coefs.b0 = val;
      biq_pkg::REG_B1: coefs.b1 = val;
      biq_pkg::REG_B2: coefs.b2 = val;
      biq_pkg::REG_A1: coefs.a1 = val;
      biq_pkg::REG_A2: coefs.a2 = val;
      default: ;
    endcase
  endtask

  task automatic load_coefs(input biq_pkg::coef_set_t cs);
    cfg_write(biq_pkg::REG_B0, cs.b0);
    cfg_write(biq_pkg::REG_B1, cs.b1);
    cfg_write(biq_pkg::REG_B2, cs.b2);
    cfg_write(biq_pkg::REG_A1, cs.a1);
    cfg_write(biq_pkg::REG_A2, cs.a2);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sampled mid-cycle so that all edge updates have settled
  task automatic wait_idle();
    do
      @(negedge clk);
    while (x_pending_q.size() != 0 || x_valid || y_expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    biq_pkg::coef_set_t cs;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default low-pass: full-scale steps and tiny values
    x_pending_q = '{16'sh0000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                    16'sh0001, 16'shFFFF};
    wait_idle();

    // products whose low 16 bits come out zero, plus ignored writes
    load_coefs('{b0: 16'sh4000, b1: 16'sh0001, b2: '0, a1: '0, a2: '0});
    for (int i = int'(biq_pkg::REG_A2) + 1; i < (1 << biq_pkg::IDX_W); i++)
      cfg_write(biq_pkg::IDX_W'(i), biq_pkg::coef_t'($urandom));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    x_pending_q = '{16'shFFFF, 16'shC000, 16'sh0005};
    wait_idle();

    // upper and lower clip
    load_coefs('{b0: 16'sh7FFF, b1: 16'sh7FFF, b2: 16'sh7FFF,
                 a1: 16'sh7FFF, a2: 16'sh7FFF});
    x_pending_q = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                    16'sh8000, 16'sh8000, 16'sh8000};
    wait_idle();

    load_coefs('{b0: 16'sh8000, b1: 16'sh8000, b2: 16'sh8000,
                 a1: 16'sh8000, a2: 16'sh8000});
    x_pending_q = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000};
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0)
        cs = '{b0: biq_pkg::B0_RESET, b1: biq_pkg::B1_RESET,
               b2: biq_pkg::B2_RESET, a1: biq_pkg::A1_RESET,
               a2: biq_pkg::A2_RESET};
      else if (ph % 2 == 1)
        cs = '{b0: pick_coef(), b1: pick_coef(), b2: pick_coef(),
               a1: pick_coef(), a2: pick_coef()};
      else
        cs = '{b0: biq_pkg::coef_t'(int'($urandom_range(0, 16383)) - 8192),
               b1: biq_pkg::coef_t'(int'($urandom_range(0, 16383)) - 8192),
               b2: biq_pkg::coef_t'(int'($urandom_range(0, 16383)) - 8192),
               a1: biq_pkg::coef_t'(int'($urandom_range(0, 32767)) - 8192),
               a2: biq_pkg::coef_t'(int'($urandom_range(0, 16383)) - 12288)};
      load_coefs(cs);
      x_idle_on = (ph != 3 && ph != 5);
      y_idle_on = (ph != 3);
      for (int k = 0; k < PHASE_ITEMS; k++)
        x_pending_q.push_back(pick_sample());
      // receiver stalls for a long stretch while the sender keeps offering
      if (ph == 5)
        hold_req++;
      wait_idle();
    end

    if (mismatches == 0 && y_expected_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin : watchdog
    #1500000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/biq_pkg.sv
hw/rtl/biq_coef_regs.sv
hw/rtl/biq_term.sv
hw/rtl/biquad_iir_q15_unit.sv
verif/testbench.sv
